@@ rtl/core/async_hdlc_deframer_macros.svh @@
// assertion helpers for the deframer
`ifndef ASYNC_HDLC_DEFRAMER_MACROS_SVH
`define ASYNC_HDLC_DEFRAMER_MACROS_SVH

`ifndef ASSERT_OFF

// checked on every clock edge once reset is released
`define AHD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define AHD_ASSERT_NR(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define AHD_ASSERT(name, prop, msg)
`define AHD_ASSERT_NR(name, prop, msg)

`endif

`endif

@@ rtl/core/ahdlc_pkg.sv @@
`default_nettype none

package ahdlc_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 13;
  localparam int unsigned KindW  = 2;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [ByteW-1:0] FLAG_BYTE = 8'h7e;
  localparam logic [ByteW-1:0] ESC_BYTE  = 8'h7d;
  localparam logic [ByteW-1:0] ESC_XOR   = 8'h20;

  localparam logic [LenW-1:0] MAX_LEN_RESET = 13'd2048;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_FRAME   = 2'd1,
    PH_ESCAPED = 2'd2
  } rx_phase_e;

  typedef enum logic [KindW-1:0] {
    KIND_DATA  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ABORT = 2'd2,
    KIND_RAW   = 2'd3
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FRAMING_ON = 1'b0,
    REG_MAX_LEN    = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    kind_e             kind;
    logic [ByteW-1:0]  data_byte;
    logic [LenW-1:0]   frame_length;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/core/async_hdlc_deframer.sv @@
// async_hdlc_deframer: byte-stuffed asynchronous hdlc deframer
//
// s_axis carries one received link byte per item in tdata[7:0].
// m_axis carries one result item: tuser[1:0] is the kind (data, frame end,
// abort, raw), tdata[7:0] the unstuffed or raw byte, tdata[20:8] the frame
// length of a frame end. With framing on, hunt bytes, an escape that starts
// a stuffed pair and a flag with a zero byte count give no result item.
// cfg writes framing_on (index 0, bit 0) and max_frame_len (index 1) and are
// always ready; write only while the block is idle.
// Each byte is taken into the input register, then decoded into the output
// register.
// Throughput: one item per cycle while the skid register is empty; the phase
// and byte count update in the single decode stage, so the next byte can follow at once.
// A skid register behind the output register absorbs one result when the
// sink stalls; s_axis tready drops only while that skid register is full.
// Reset empties all stages, turns framing off, sets max_frame_len to 2048
// and puts the deframer in hunt with a zero byte count.
`default_nettype none

module async_hdlc_deframer (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // tdata: rx_byte[7:0]
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [ahdlc_pkg::ByteW-1:0]     s_axis_tdata,
  // tdata: out_byte[7:0], frame_length[20:8], zero[23:21]
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [23:0]                          m_axis_tdata,
  // tuser: kind[1:0]
  output logic [ahdlc_pkg::KindW-1:0]          m_axis_tuser,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [ahdlc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [ahdlc_pkg::LenW-1:0]      cfg_data_i
);
  import ahdlc_pkg::*;

  `include "async_hdlc_deframer_macros.svh"

  logic              framing_on_q;
  logic [LenW-1:0]   max_len_q;

  logic              in_valid_q;
  logic [ByteW-1:0]  in_byte_q;

  rx_phase_e         phase_q, phase_d;
  logic [LenW-1:0]   count_q, count_d;

  logic              out_valid_q, skid_valid_q;
  res_t              out_q, skid_q;

  logic              fire;
  logic              has_res;
  res_t              res;
  logic              out_pop;
  logic              push;
  logic              is_flag, is_esc, too_long;
  logic [LenW-1:0]   count_inc;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      framing_on_q <= 1'b0;
      max_len_q    <= MAX_LEN_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_FRAMING_ON: framing_on_q <= cfg_data_i[0];
        REG_MAX_LEN:    max_len_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  assign fire          = in_valid_q && !skid_valid_q;
  assign s_axis_tready = !in_valid_q || !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  assign is_flag   = (in_byte_q == FLAG_BYTE);
  assign is_esc    = (in_byte_q == ESC_BYTE);
  assign too_long  = (count_q >= max_len_q);
  assign count_inc = count_q + LenW'(1);

  // next phase and byte count
  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    case (phase_q)
      PH_FRAME: begin
        if (is_esc) begin
          phase_d = PH_ESCAPED;
        end else if (is_flag) begin
          count_d = '0;
        end else if (too_long) begin
          phase_d = PH_HUNT;
          count_d = '0;
        end else begin
          count_d = count_inc;
        end
      end
      PH_ESCAPED: begin
        if (is_esc || is_flag || too_long) begin
          phase_d = PH_HUNT;
          count_d = '0;
        end else begin
          phase_d = PH_FRAME;
          count_d = count_inc;
        end
      end
      default: begin
        count_d = '0;
        phase_d = is_flag ? PH_FRAME : PH_HUNT;
      end
    endcase
  end

  // result of the current byte
  always_comb begin
    has_res = 1'b0;
    res     = '{kind: KIND_RAW, data_byte: '0, frame_length: '0};
    if (!framing_on_q) begin
      has_res       = 1'b1;
      res.data_byte = in_byte_q;
    end else begin
      case (phase_q)
        PH_FRAME: begin
          if (is_esc) begin
            has_res = 1'b0;
          end else if (is_flag) begin
            has_res          = (count_q != '0);
            res.kind         = KIND_END;
            res.frame_length = count_q;
          end else if (too_long) begin
            has_res  = 1'b1;
            res.kind = KIND_ABORT;
          end else begin
            has_res       = 1'b1;
            res.kind      = KIND_DATA;
            res.data_byte = in_byte_q;
          end
        end
        PH_ESCAPED: begin
          has_res = 1'b1;
          if (is_esc || is_flag || too_long) begin
            res.kind = KIND_ABORT;
          end else begin
            res.kind      = KIND_DATA;
            res.data_byte = in_byte_q ^ ESC_XOR;
          end
        end
        default: has_res = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      count_q <= '0;
    end else if (fire && framing_on_q) begin
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

  // output register with skid stage
  assign out_pop = out_valid_q && m_axis_tready;
  assign push    = fire && has_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_pop) begin
      // skid full means nothing was pushed this cycle
      out_valid_q  <= skid_valid_q || push;
      skid_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q  <= 1'b1;
      skid_valid_q <= out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_pop) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (push) begin
      if (out_valid_q) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {3'b000, out_q.frame_length, out_q.data_byte};

  `AHD_ASSERT(skid_needs_out, skid_valid_q |-> out_valid_q, "skid full with empty output")
  `AHD_ASSERT(skid_fill_on_stall, $rose(skid_valid_q) |-> $past(out_valid_q && !m_axis_tready),
    "skid filled without output stall")
  `AHD_ASSERT(hunt_count_zero, (phase_q == PH_HUNT) |-> (count_q == '0),
    "nonzero byte count in hunt")
  `AHD_ASSERT(end_len_nonzero, (out_valid_q && (out_q.kind == KIND_END)) |->
    (out_q.frame_length != '0), "frame end with zero length")
  `AHD_ASSERT_NR(reset_empty, !rst_ni |-> (!out_valid_q && !skid_valid_q && !in_valid_q),
    "stages not empty in reset")

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

  import ahdlc_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned SettleCycles = 8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;

  logic                s_valid = 1'b0;
  logic                s_axis_tready;
  logic [ByteW-1:0]    s_data = '0;
  logic                m_axis_tvalid;
  logic                m_ready = 1'b0;
  logic [23:0]         m_axis_tdata;
  logic [KindW-1:0]    m_axis_tuser;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index = REG_FRAMING_ON;
  logic [LenW-1:0]     cfg_data = '0;

  async_hdlc_deframer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  // raw link bytes waiting to be sent, and deframed items still to come out
  logic [ByteW-1:0] link_bytes[$];
  res_t             pending_results[$];

  // deframer state as seen by the checker
  logic             framing_en = 1'b0;
  logic [LenW-1:0]  len_limit = MAX_LEN_RESET;
  rx_phase_e        link_phase = PH_HUNT;
  logic [LenW-1:0]  frame_count = '0;

  int unsigned send_gap_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned fault_count = 0;
  int unsigned cycle_count = 0;
  bit          byte_taken = 1'b0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic void queue_result(kind_e k, logic [ByteW-1:0] b, logic [LenW-1:0] n);
    res_t r;
    r.kind = k;
    r.data_byte = b;
    r.frame_length = n;
    pending_results.push_back(r);
  endfunction

  function automatic void take_frame_byte(logic [ByteW-1:0] b);
    if (frame_count >= len_limit) begin
      frame_count = '0;
      link_phase = PH_HUNT;
      queue_result(KIND_ABORT, '0, '0);
    end else begin
      frame_count = frame_count + 1'b1;
      link_phase = PH_FRAME;
      queue_result(KIND_DATA, b, '0);
    end
  endfunction

  function automatic void deframe_byte(logic [ByteW-1:0] b);
    if (!framing_en) begin
      queue_result(KIND_RAW, b, '0);
    end else begin
      case (link_phase)
        PH_FRAME: begin
          if (b == ESC_BYTE) begin
            link_phase = PH_ESCAPED;
          end else if (b == FLAG_BYTE) begin
            // back-to-back flags close nothing
            if (frame_count != '0) begin
              queue_result(KIND_END, '0, frame_count);
              frame_count = '0;
            end
          end else begin
            take_frame_byte(b);
          end
        end
        PH_ESCAPED: begin
          if (b == ESC_BYTE || b == FLAG_BYTE) begin
            frame_count = '0;
            link_phase = PH_HUNT;
            queue_result(KIND_ABORT, '0, '0);
          end else begin
            take_frame_byte(b ^ ESC_XOR);
          end
        end
        default: begin
          frame_count = '0;
          link_phase = (b == FLAG_BYTE) ? PH_FRAME : PH_HUNT;
        end
      endcase
    end
  endfunction

  // sender and receiver side, driven on the falling edge
  always @(negedge clk_i) begin
    if (!s_valid || byte_taken) begin
      if (link_bytes.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        s_data <= link_bytes.pop_front();
        s_valid <= 1'b1;
      end else begin
        s_valid <= 1'b0;
      end
    end
    m_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // sampling on the rising edge: predict accepted bytes, check result items
  always @(posedge clk_i) begin : monitor
    res_t want;
    cycle_count++;
    byte_taken = s_valid && s_axis_tready;
    if (cfg_valid && cfg_ready_o) begin
      if (cfg_reg_e'(cfg_index) == REG_FRAMING_ON) framing_en = cfg_data[0];
      else len_limit = cfg_data;
    end
    if (byte_taken) deframe_byte(s_data);
    if (m_axis_tvalid && m_ready) begin
      if (pending_results.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("unexpected item: kind %0d byte %02h len %0d", m_axis_tuser,
                   m_axis_tdata[7:0], m_axis_tdata[20:8]);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser != want.kind || m_axis_tdata[7:0] != want.data_byte ||
            m_axis_tdata[20:8] != want.frame_length || m_axis_tdata[23:21] != 3'b000) begin
          fault_count++;
          if (fault_count <= 10)
            $display("mismatch: kind %0d/%0d byte %02h/%02h len %0d/%0d pad %0d",
                     want.kind, m_axis_tuser, want.data_byte, m_axis_tdata[7:0],
                     want.frame_length, m_axis_tdata[20:8], m_axis_tdata[23:21]);
        end
      end
    end
    if (cycle_count > CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [LenW-1:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // sender stops until everything sent has come out, plus pipeline slack
  task automatic wait_quiet();
    do @(negedge clk_i);
    while (link_bytes.size() != 0 || s_valid || pending_results.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  function automatic logic [ByteW-1:0] pick_byte();
    logic [ByteW-1:0] b;
    case ($urandom_range(15))
      0: b = FLAG_BYTE;
      1: b = ESC_BYTE;
      2: b = FLAG_BYTE ^ ESC_XOR;
      default: b = ByteW'($urandom_range(255));
    endcase
    return b;
  endfunction

  function automatic void add_frame(int unsigned n);
    logic [ByteW-1:0] b;
    link_bytes.push_back(FLAG_BYTE);
    for (int unsigned i = 0; i < n; i++) begin
      b = pick_byte();
      // control bytes must be stuffed, others now and then too
      if (b == FLAG_BYTE || b == ESC_BYTE || $urandom_range(15) == 0) begin
        link_bytes.push_back(ESC_BYTE);
        link_bytes.push_back(b ^ ESC_XOR);
      end else begin
        link_bytes.push_back(b);
      end
    end
    link_bytes.push_back(FLAG_BYTE);
  endfunction

  function automatic void add_noise();
    case ($urandom_range(3))
      0: repeat ($urandom_range(1, 4)) link_bytes.push_back(pick_byte());
      1: begin
        link_bytes.push_back(ESC_BYTE);
        link_bytes.push_back(ESC_BYTE);
      end
      2: begin
        link_bytes.push_back(ESC_BYTE);
        link_bytes.push_back(FLAG_BYTE);
      end
      default: begin
        // frame cut short by an escaped flag
        link_bytes.push_back(FLAG_BYTE);
        repeat ($urandom_range(0, 5)) link_bytes.push_back(ByteW'($urandom_range(255)));
        link_bytes.push_back(ESC_BYTE);
        link_bytes.push_back(FLAG_BYTE);
      end
    endcase
  endfunction

  function automatic void random_traffic(int unsigned n_bytes, int unsigned long_len);
    int unsigned start;
    start = link_bytes.size();
    while (link_bytes.size() - start < n_bytes) begin
      if ($urandom_range(9) < 8) begin
        if ($urandom_range(19) == 0) add_frame($urandom_range(long_len - 1, long_len + 1));
        else add_frame($urandom_range(12));
      end else begin
        add_noise();
      end
    end
  endfunction

  initial begin
    rst_ni <= 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_gap_pct = 11;
    sink_stall_pct = 84;

    // framing is off after reset: control bytes pass through raw
    link_bytes = '{8'h00, 8'hff, FLAG_BYTE, ESC_BYTE};
    wait_quiet();

    write_reg(REG_FRAMING_ON, 13'd1);
    write_reg(REG_MAX_LEN, 13'd4);
    @(posedge clk_i);
    link_bytes = '{
      8'h55, FLAG_BYTE,                      // hunt garbage, then open
      FLAG_BYTE,                             // empty frame
      8'h00, 8'hff, ESC_BYTE, 8'h5e,         // data, stuffed flag
      FLAG_BYTE,                             // end, length 3
      ESC_BYTE, ESC_BYTE,                    // escape then escape
      FLAG_BYTE, ESC_BYTE, FLAG_BYTE,        // escape then flag
      FLAG_BYTE, 8'h01, 8'h02, 8'h03,
      ESC_BYTE, 8'h24, 8'h05,                // hits the limit of 4 and overflows
      FLAG_BYTE, ESC_BYTE, 8'h5d, FLAG_BYTE  // stuffed escape, end
    };
    wait_quiet();

    write_reg(REG_MAX_LEN, MAX_LEN_RESET);
    @(posedge clk_i);
    random_traffic(200, 40);
    wait_quiet();
    random_traffic(200, 40);
    wait_quiet();

    write_reg(REG_MAX_LEN, 13'd1);
    @(posedge clk_i);
    random_traffic(150, 2);
    // leave a frame open across the passthrough stretch
    link_bytes.push_back(FLAG_BYTE);
    link_bytes.push_back(8'h11);
    wait_quiet();

    write_reg(REG_FRAMING_ON, 13'd0);
    @(posedge clk_i);
    repeat (100) link_bytes.push_back(ByteW'($urandom_range(255)));
    wait_quiet();

    send_gap_pct = 84;
    sink_stall_pct = 11;
    write_reg(REG_FRAMING_ON, 13'd1);
    write_reg(REG_MAX_LEN, 13'd4096);
    @(posedge clk_i);
    random_traffic(100, 40);
    add_frame(300);
    random_traffic(100, 40);
    wait_quiet();

    send_gap_pct = 0;
    sink_stall_pct = 0;
    write_reg(REG_MAX_LEN, 13'd7);
    @(posedge clk_i);
    random_traffic(400, 8);
    wait_quiet();

    if (fault_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/ahdlc_pkg.sv
rtl/core/async_hdlc_deframer.sv
tb/sv/tb_top.sv
